@@ design/keyframe_setpoint_interpolator_assert.svh @@
// ----------------------------------------------------------------------------
// Keyframe setpoint interpolator assertion macros
// Clocked, reset-qualified assertion helpers used by the RTL.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_SETPOINT_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_SETPOINT_INTERPOLATOR_ASSERT_SVH

// Implication checked on every rising edge outside reset
`define KFSI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequence checked in the cycle after the antecedent
`define KFSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/kfsi_pkg.sv @@
// ----------------------------------------------------------------------------
// kfsi_pkg
// Shared constants, codes and types of the keyframe setpoint interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package kfsi_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int IDX_W      = $clog2(MAX_FRAMES);
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int DATA_W     = 32;
  localparam int NUM_CH     = 4;
  localparam int CH_W       = $clog2(NUM_CH);
  // entry layout: time in the low word, then roll, pitch, yaw, altitude
  localparam int ENTRY_W    = DATA_W * (NUM_CH + 1);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_QUERY = 2'd2
  } kfsi_op_e;

  // request to the interpolation unit
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] ta;
    logic [DATA_W-1:0] tb;
    logic [DATA_W-1:0] t;
  } kfsi_lerp_req_t;

  // response from the interpolation unit
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] value;
  } kfsi_lerp_rsp_t;

endpackage

`default_nettype wire

@@ design/kfsi_ram.sv @@
// ----------------------------------------------------------------------------
// kfsi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kfsi_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ design/kfsi_lerp.sv @@
// ----------------------------------------------------------------------------
// kfsi_lerp
// Iterative interpolation unit: a + (b - a) * (t - ta) / (tb - ta), a
// multiply step then a restoring divide of one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kfsi_lerp
  import kfsi_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire kfsi_lerp_req_t req_i,
  output      kfsi_lerp_rsp_t rsp_o
);

  localparam int MagW = DATA_W + 1;          // |b - a| needs 33 bits
  localparam int ProdW = MagW + DATA_W;      // full product
  localparam int StepW = $clog2(MagW + 1);

  typedef enum logic [2:0] {
    L_IDLE,
    L_MUL,
    L_DIV,
    L_FIN,
    L_DONE
  } lerp_state_e;

  lerp_state_e        state_q;
  logic [MagW-1:0]    mag_q;
  logic               neg_q;
  logic [DATA_W-1:0]  off_q;
  logic [DATA_W-1:0]  span_q;
  logic [DATA_W-1:0]  a_q;
  logic [DATA_W-1:0]  rem_q;
  logic [MagW-1:0]    quo_q;
  logic [StepW-1:0]   step_q;
  logic [DATA_W-1:0]  val_q;

  logic [MagW-1:0]    diff;
  logic [ProdW-1:0]   prod;
  logic [MagW-1:0]    rem_sh;
  logic [MagW-1:0]    rem_sub;
  logic               ge;

  // signed difference of the channel values and its magnitude
  assign diff    = {req_i.b[DATA_W-1], req_i.b} - {req_i.a[DATA_W-1], req_i.a};
  assign prod    = ProdW'(mag_q) * ProdW'(off_q);
  // one restoring divide step
  assign rem_sh  = {rem_q, quo_q[MagW-1]};
  assign rem_sub = rem_sh - {1'b0, span_q};
  assign ge      = rem_sh >= {1'b0, span_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        L_IDLE: begin
          if (req_i.start) begin
            a_q    <= req_i.a;
            neg_q  <= diff[MagW-1];
            mag_q  <= diff[MagW-1] ? (~diff + MagW'(1)) : diff;
            off_q  <= req_i.t - req_i.ta;
            span_q <= req_i.tb - req_i.ta;
            if (req_i.ta == req_i.tb) begin
              val_q   <= req_i.a;
              state_q <= L_DONE;
            end else begin
              state_q <= L_MUL;
            end
          end
        end
        L_MUL: begin
          // quotient is at most |b - a|, so the high part is below the span
          rem_q   <= prod[ProdW-1:MagW];
          quo_q   <= prod[MagW-1:0];
          step_q  <= '0;
          state_q <= L_DIV;
        end
        L_DIV: begin
          rem_q  <= ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
          quo_q  <= {quo_q[MagW-2:0], ge};
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(MagW - 1)) begin
            state_q <= L_FIN;
          end
        end
        L_FIN: begin
          val_q   <= neg_q ? (a_q - quo_q[DATA_W-1:0]) : (a_q + quo_q[DATA_W-1:0]);
          state_q <= L_DONE;
        end
        L_DONE: begin
          state_q <= L_IDLE;
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign rsp_o.done  = (state_q == L_DONE);
  assign rsp_o.value = val_q;

endmodule

`default_nettype wire

@@ design/keyframe_setpoint_interpolator.sv @@
// A query's duration depends on the keyframe RAM's single read port and the
// shared interpolation unit. After the query word, the block goes straight to
// output when it is not started or no frames are in use. When the time is at
// or outside the keyframe span, it reads the first and last frames and outputs.
// When it interpolates, it reads the end frames, scans keyframe pairs in turn,
// runs the interpolation unit for each channel (multiply and divide, or neither
// when the bracketing times are equal) and then outputs. Write and start
// words leave the input ready. The input is not ready while a query is in
// progress. A finished result sits in the output register while the next word
// is accepted. A query whose result is waiting for that register holds off the
// input until the register drains.
// ----------------------------------------------------------------------------
// keyframe_setpoint_interpolator
// Keyframe table with linear interpolation of roll, pitch, yaw and altitude.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_setpoint_interpolator
  import kfsi_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [4:0]   cfg_wdata_i,      // frame_count
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // [3:0] entry_index, [35:4] entry_time_ms, [67:36] entry_roll,
  // [99:68] entry_pitch, [131:100] entry_yaw, [163:132] entry_altitude,
  // [195:164] now_ms, [199:196] zero
  input  wire logic [199:0] s_axis_tdata,
  input  wire logic [1:0]   s_axis_tuser,     // [1:0] operation
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [31:0] roll_out, [63:32] pitch_out, [95:64] yaw_out, [127:96] altitude_out
  output      logic [127:0] m_axis_tdata,
  output      logic [1:0]   m_axis_tuser      // [0] valid_res, [1] complete
);

  `include "keyframe_setpoint_interpolator_assert.svh"

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD0,
    S_RDL,
    S_CHK,
    S_SCAN,
    S_SCANW,
    S_LERP,
    S_LWAIT,
    S_OUT
  } state_e;

  state_e                 state_q;
  logic [CNT_W-1:0]       frame_cnt_q;
  logic                   started_q;
  logic [DATA_W-1:0]      start_time_q;
  logic [DATA_W-1:0]      elapsed_q;
  logic [IDX_W-1:0]       scan_q;
  logic [CH_W-1:0]        ch_q;
  logic [ENTRY_W-1:0]     prev_q;
  logic [ENTRY_W-1:0]     cur_q;
  logic [DATA_W-1:0]      res_q [NUM_CH];
  logic                   valid_q;
  logic                   complete_q;

  logic [CNT_W-1:0]       n_used;
  logic [IDX_W-1:0]       last_idx;
  logic                   in_acc;
  kfsi_op_e               op;
  logic [ENTRY_W-1:0]     wr_entry;
  logic [ENTRY_W-1:0]     rd_data;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [DATA_W-1:0]      now_ms;
  logic                   out_free;
  kfsi_lerp_req_t         lerp_req;
  kfsi_lerp_rsp_t         lerp_rsp;

  // input word decode
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign op       = kfsi_op_e'(s_axis_tuser);
  assign wr_entry = s_axis_tdata[163:4];
  assign now_ms   = s_axis_tdata[195:164];
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // frames in use, clamped to the table size
  assign n_used   = (frame_cnt_q > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : frame_cnt_q;
  assign last_idx = IDX_W'(n_used - CNT_W'(1));

  // keyframe read address per sequencer step
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state_q)
      S_RD0:  rd_en = 1'b1;
      S_RDL: begin
        rd_en   = 1'b1;
        rd_addr = last_idx;
      end
      S_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = scan_q;
      end
      default: ;
    endcase
  end

  kfsi_ram #(
    .Width(ENTRY_W),
    .Depth(MAX_FRAMES)
  ) u_frames (
    .clk_i   (clk_i),
    .we_i    (in_acc && (op == OP_WRITE)),
    .waddr_i (s_axis_tdata[IDX_W-1:0]),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // channel handed to the interpolation unit
  assign lerp_req.start = (state_q == S_LERP);
  assign lerp_req.a     = prev_q[DATA_W*(32'(ch_q)+1) +: DATA_W];
  assign lerp_req.b     = cur_q[DATA_W*(32'(ch_q)+1) +: DATA_W];
  assign lerp_req.ta    = prev_q[DATA_W-1:0];
  assign lerp_req.tb    = cur_q[DATA_W-1:0];
  assign lerp_req.t     = elapsed_q;

  kfsi_lerp u_lerp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lerp_req),
    .rsp_o  (lerp_rsp)
  );

  // sequencer, state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      frame_cnt_q   <= '0;
      started_q     <= 1'b0;
      start_time_q  <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        frame_cnt_q <= cfg_wdata_i;
      end
      // output drains; a new word loaded in S_OUT takes its place
      if (m_axis_tvalid && m_axis_tready && (state_q != S_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (op)
              OP_START: begin
                start_time_q <= now_ms;
                started_q    <= 1'b1;
              end
              OP_QUERY: begin
                elapsed_q  <= now_ms - start_time_q;
                valid_q    <= 1'b0;
                complete_q <= 1'b0;
                for (int c = 0; c < NUM_CH; c++) begin
                  res_q[c] <= '0;
                end
                state_q <= (started_q && (n_used != '0)) ? S_RD0 : S_OUT;
              end
              default: ;
            endcase
          end
        end
        S_RD0: state_q <= S_RDL;
        S_RDL: begin
          prev_q  <= rd_data;
          state_q <= S_CHK;
        end
        S_CHK: begin
          complete_q <= elapsed_q > rd_data[DATA_W-1:0];
          if (elapsed_q <= prev_q[DATA_W-1:0]) begin
            valid_q <= 1'b1;
            for (int c = 0; c < NUM_CH; c++) begin
              res_q[c] <= prev_q[DATA_W*(c+1) +: DATA_W];
            end
            state_q <= S_OUT;
          end else if (elapsed_q >= rd_data[DATA_W-1:0]) begin
            valid_q <= 1'b1;
            for (int c = 0; c < NUM_CH; c++) begin
              res_q[c] <= rd_data[DATA_W*(c+1) +: DATA_W];
            end
            state_q <= S_OUT;
          end else begin
            scan_q  <= IDX_W'(1);
            state_q <= S_SCAN;
          end
        end
        S_SCAN: state_q <= S_SCANW;
        S_SCANW: begin
          // prev_q holds frame scan-1, rd_data frame scan
          if ((elapsed_q >= prev_q[DATA_W-1:0]) && (elapsed_q <= rd_data[DATA_W-1:0])) begin
            cur_q   <= rd_data;
            ch_q    <= '0;
            state_q <= S_LERP;
          end else if (scan_q == last_idx) begin
            state_q <= S_OUT;
          end else begin
            prev_q  <= rd_data;
            scan_q  <= scan_q + IDX_W'(1);
            state_q <= S_SCAN;
          end
        end
        S_LERP: state_q <= S_LWAIT;
        S_LWAIT: begin
          if (lerp_rsp.done) begin
            res_q[ch_q] <= lerp_rsp.value;
            if (ch_q == CH_W'(NUM_CH - 1)) begin
              valid_q <= 1'b1;
              state_q <= S_OUT;
            end else begin
              ch_q    <= ch_q + CH_W'(1);
              state_q <= S_LERP;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= {complete_q, valid_q};
            m_axis_tdata  <= {res_q[3], res_q[2], res_q[1], res_q[0]};
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // checks
  `KFSI_ASSERT_IMP(a_lerp_done_in_wait, lerp_rsp.done, state_q == S_LWAIT,
                   "interpolation finished outside the wait step")
  `KFSI_ASSERT_IMP(a_scan_in_range, state_q == S_SCANW,
                   (scan_q <= last_idx) && (scan_q != '0),
                   "scan index outside the frames in use")
  `KFSI_ASSERT_NEXT(a_query_busy, in_acc && (op == OP_QUERY), !s_axis_tready,
                    "input ready right after a query word")

endmodule

`default_nettype wire

@@ tb/tb_keyframe_setpoint_interpolator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyframe_setpoint_interpolator
// Drives keyframe writes, mission starts, unused-op words and setpoint queries into the
// interpolator with random gaps and output stalls. Every query result is
// checked field by field against an in-bench model of the keyframe table.
// ----------------------------------------------------------------------------
module tb_keyframe_setpoint_interpolator;
  import kfsi_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [1:0]       op;
    logic [3:0]       idx;
    logic [31:0]      tms;
    logic [3:0][31:0] ch;     // roll, pitch, yaw, altitude
    logic [31:0]      now;
  } word_t;

  typedef struct packed {
    logic             valid;
    logic             complete;
    logic [3:0][31:0] ch;
  } setpoint_t;

  typedef struct {
    word_t     w;
    bit        typed;
    setpoint_t sp;
  } row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [4:0]   cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [199:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  keyframe_setpoint_interpolator u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // model state
  logic [31:0]      kf_time [MAX_FRAMES];
  logic [3:0][31:0] kf_ch   [MAX_FRAMES];
  logic [31:0]      mission_t0 = '0;
  bit               running = 1'b0;
  logic [4:0]       frame_count = '0;

  setpoint_t setpoint_q[$];
  int        errors = 0;
  int        idle_cycles = 0;
  bit        cur_typed = 1'b0;
  setpoint_t cur_sp;
  bit        hold_req = 1'b0;

  // exact a + (b-a)*(t-ta)/(tb-ta), quotient truncated toward zero
  function automatic logic [31:0] lerp(logic [31:0] ta, logic [31:0] a,
                                       logic [31:0] tb, logic [31:0] b,
                                       logic [31:0] t);
    longint    diff;
    bit [63:0] mag;
    bit [63:0] q;
    if (ta == tb) return a;
    diff = longint'($signed(b)) - longint'($signed(a));
    mag  = (diff < 0 ? -diff : diff);
    mag  = mag * 64'(t - ta);
    q    = mag / 64'(tb - ta);
    return diff < 0 ? a - q[31:0] : a + q[31:0];
  endfunction

  // applies one word to the table model; returns the setpoint of a query
  function automatic setpoint_t apply_word(word_t w);
    setpoint_t   sp = '0;
    int          n;
    logic [31:0] el;
    n = (frame_count > MAX_FRAMES) ? MAX_FRAMES : frame_count;
    case (w.op)
      OP_WRITE: begin
        kf_time[w.idx] = w.tms;
        kf_ch[w.idx]   = w.ch;
      end
      OP_START: begin
        mission_t0 = w.now;
        running    = 1'b1;
      end
      OP_QUERY: begin
        if (running && n > 0) begin
          el = w.now - mission_t0;
          sp.complete = el > kf_time[n-1];
          if (el <= kf_time[0]) begin
            sp.valid = 1'b1;
            sp.ch    = kf_ch[0];
          end else if (el >= kf_time[n-1]) begin
            sp.valid = 1'b1;
            sp.ch    = kf_ch[n-1];
          end else begin
            for (int k = 0; k + 1 < n; k++) begin
              if (!sp.valid && el >= kf_time[k] && el <= kf_time[k+1]) begin
                sp.valid = 1'b1;
                for (int c = 0; c < 4; c++)
                  sp.ch[c] = lerp(kf_time[k], kf_ch[k][c], kf_time[k+1], kf_ch[k+1][c], el);
              end
            end
          end
        end
      end
      default: ;
    endcase
    return sp;
  endfunction

  // monitor: predict on input words, compare on output words
  always @(posedge clk_i) begin
    setpoint_t sp, got, want;
    word_t     wi;
    if (rst_ni) begin
      if (cfg_we_i) frame_count = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        wi = {s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[35:4],
              s_axis_tdata[163:36], s_axis_tdata[195:164]};
        sp = apply_word(wi);
        if (s_axis_tuser == OP_QUERY) setpoint_q.push_back(cur_typed ? cur_sp : sp);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser[0], m_axis_tuser[1], m_axis_tdata};
        if (setpoint_q.size() == 0) begin
          $error("unexpected setpoint word");
          errors++;
        end else begin
          want = setpoint_q.pop_front();
          if (got.valid !== want.valid) begin
            $error("valid_res exp %0h got %0h", want.valid, got.valid); errors++;
          end
          if (got.complete !== want.complete) begin
            $error("complete exp %0h got %0h", want.complete, got.complete); errors++;
          end
          if (got.ch[0] !== want.ch[0]) begin
            $error("roll_out exp %h got %h", want.ch[0], got.ch[0]); errors++;
          end
          if (got.ch[1] !== want.ch[1]) begin
            $error("pitch_out exp %h got %h", want.ch[1], got.ch[1]); errors++;
          end
          if (got.ch[2] !== want.ch[2]) begin
            $error("yaw_out exp %h got %h", want.ch[2], got.ch[2]); errors++;
          end
          if (got.ch[3] !== want.ch[3]) begin
            $error("altitude_out exp %h got %h", want.ch[3], got.ch[3]); errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("tb_keyframe_setpoint_interpolator: done, errors");
      $finish;
    end
  end

  function automatic int gap_len();
    int r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // output side: random stalls, one long hold on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (400) @(negedge clk_i);
        hold_req = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready = 1'b0;
        repeat (gap_len()) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 80)) @(negedge clk_i);
    end
  end

  // offer one word and wait for its handshake; called at a falling edge
  task automatic send_word(word_t w, bit typed, setpoint_t sp);
    s_axis_tdata  = {4'b0, w.now, w.ch, w.tms, w.idx};
    s_axis_tuser  = w.op;
    cur_typed     = typed;
    cur_sp        = sp;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (gap_len() != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap_len()) @(negedge clk_i);
    end
  endtask

  // register write once all results are out and the block has settled
  task automatic set_frame_count(logic [4:0] n);
    s_axis_tvalid = 1'b0;
    @(negedge clk_i);
    while (setpoint_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = n;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  function automatic logic [31:0] rand_chan();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // one random phase: fresh ascending table, start, then mixed words
  task automatic run_phase(logic [4:0] fc, logic [31:0] step, int words,
                           bit hold = 1'b0);
    word_t       w;
    logic [31:0] base, t0, span;
    int          r;
    set_frame_count(fc);
    base = $urandom_range(0, 1000);
    span = step * 16;
    for (int k = 0; k < MAX_FRAMES; k++) begin
      w = '0;
      w.op  = OP_WRITE;
      w.idx = 4'(k);
      w.tms = base + k * step + ((step > 4) ? $urandom_range(0, step / 4) : 0);
      for (int c = 0; c < 4; c++) w.ch[c] = rand_chan();
      send_word(w, 1'b0, '0);
    end
    t0 = $urandom();
    w = '0; w.op = OP_START; w.now = t0;
    send_word(w, 1'b0, '0);
    // long receiver hold while the words below keep coming
    if (hold) hold_req = 1'b1;
    for (int i = 0; i < words; i++) begin
      w = '0;
      w.idx = 4'($urandom());
      w.tms = $urandom();
      for (int c = 0; c < 4; c++) w.ch[c] = rand_chan();
      r = $urandom_range(0, 99);
      if (r < 12) begin
        w.op = OP_WRITE;
        // mostly in order, sometimes out of order noise
        if (r < 9) w.tms = base + w.idx * step;
      end else if (r < 17) begin
        w.op = OP_START;
        t0 = $urandom();
        w.now = t0;
      end else if (r < 20) begin
        w.op = OP_UNUSED;
        w.now = $urandom();
      end else begin
        w.op = OP_QUERY;
        if (r < 90) w.now = t0 + base + $urandom_range(0, span + span / 8 + 2);
        else        w.now = $urandom();
      end
      send_word(w, 1'b0, '0);
    end
  endtask

  initial begin
    row_t        rows[$];
    row_t        rw;
    word_t       w;
    logic [31:0] q_off [4] = '{32'd5, 32'd510, 32'hFFFF_FFFF, 32'd20000};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    set_frame_count(5'd16);

    // directed table
    rw = '{w: '0, typed: 1'b1, sp: '0};
    rw.w.op = OP_QUERY; rw.w.now = 32'd5;           // not started
    rows.push_back(rw);
    for (int k = 0; k < MAX_FRAMES; k++) begin
      rw = '{w: '0, typed: 1'b0, sp: '0};
      rw.w.op    = OP_WRITE;
      rw.w.idx   = 4'(k);
      rw.w.tms   = (k == 15) ? 32'hFFFF_FFFF : 32'd10 + k * 1000;
      rw.w.ch[0] = k[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
      rw.w.ch[1] = ~rw.w.ch[0];
      rw.w.ch[2] = k * 32'h0100_0000;
      rw.w.ch[3] = 32'hFFFF_0000 ^ k;
      rows.push_back(rw);
    end
    rw = '{w: '1, typed: 1'b0, sp: '0};             // unused op, ignored
    rows.push_back(rw);
    rw = '{w: '0, typed: 1'b0, sp: '0};
    rw.w.op = OP_START; rw.w.now = 32'hFFFF_FFF0;   // start near wrap
    rows.push_back(rw);
    rw.w.op = OP_QUERY;
    foreach (q_off[j]) begin
      rw.w.now = 32'hFFFF_FFF0 + q_off[j];
      rows.push_back(rw);
    end
    rw.w.op = OP_START; rw.w.now = 32'd1000;        // relatch while started
    rows.push_back(rw);
    rw.w.op = OP_QUERY;
    rows.push_back(rw);
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].sp);

    // random phases over several frame counts and time scales
    run_phase(5'd16, 32'd1000, 200);
    run_phase(5'd2, 32'd50, 200, 1'b1);
    run_phase(5'd1, 32'd7, 150);
    run_phase(5'd3, 32'h0800_0000, 200);
    run_phase(5'd16, 32'd0, 150);                   // equal frame times
    run_phase(5'd31, 32'd300, 200);                 // count clamps to max
    run_phase(5'd0, 32'd100, 100);
    run_phase(5'd8, 32'd3, 200);
    run_phase(5'd16, 32'h0FFF_FFFF, 250);

    s_axis_tvalid = 1'b0;
    @(negedge clk_i);
    while (setpoint_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0)
      $display("tb_keyframe_setpoint_interpolator: done, clean");
    else
      $display("tb_keyframe_setpoint_interpolator: done, errors");
    $finish;
  end

endmodule
